// File: hw/rtl/lcdseq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the character-LCD nibble sequencer.
package lcdseq_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 8;
    localparam int COL_W   = 6;
    localparam int NIB_W   = 4;
    localparam int IDX_W   = 4;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR    = 3'd0,
        OP_COMMAND = 3'd1,
        OP_GOTO    = 3'd2,
        OP_NUMBER  = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_INIT    = 3'd5
    } t_op;

    // Shape of the nibble sequence the back end plays out
    typedef enum logic [1:0] {
        K_BYTE = 2'd0,   // one byte, two nibbles
        K_PAIR = 2'd1,   // two data bytes, four nibbles
        K_INIT = 2'd2    // power-up sequence, eleven nibbles
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               rs;
        logic               lw;       // long settle after the low nibble
        logic [VALUE_W-1:0] b0;
        logic [VALUE_W-1:0] b1;
        logic               crow;
        logic [COL_W-1:0]   ccol;
    } t_entry;

    localparam logic [VALUE_W-1:0] GLYPH_BASE   = 8'd192;
    localparam logic [VALUE_W-1:0] ASCII_ZERO   = 8'd48;
    localparam logic [VALUE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [6:0]         NUMBER_MAX   = 7'd99;
    localparam logic [IDX_W-1:0]   INIT_LAST    = 4'd10;
    localparam logic [IDX_W-1:0]   PAIR_LAST    = 4'd3;

    localparam logic [VALUE_W-1:0] GLYPH_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    // Init: lone function-set nibble, then 0x28, 0x01, 0x06, 0x0C, 0x01
    function automatic logic [NIB_W-1:0] init_nibble(input logic [IDX_W-1:0] idx);
        logic [NIB_W-1:0] nib;
        case (idx)
            4'd0:    nib = 4'h2;
            4'd1:    nib = 4'h2;
            4'd2:    nib = 4'h8;
            4'd3:    nib = 4'h0;
            4'd4:    nib = 4'h1;
            4'd5:    nib = 4'h0;
            4'd6:    nib = 4'h6;
            4'd7:    nib = 4'h0;
            4'd8:    nib = 4'hC;
            4'd9:    nib = 4'h0;
            4'd10:   nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

// File: hw/rtl/lcdseq_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with the LCD request payload.
interface lcdseq_req_if;
    import lcdseq_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
    logic               row;
    logic [COL_W-1:0]   column;

    modport source (output valid, output operation, output value, output row,
                    output column, input ready);
    modport sink   (input valid, input operation, input value, input row,
                    input column, output ready);
endinterface

// File: hw/rtl/lcdseq_nib_if.sv
`timescale 1ns / 1ps
// Nibble channel: valid/ready handshake with one 4-bit bus transfer.
interface lcdseq_nib_if;
    import lcdseq_pkg::*;

    logic             valid;
    logic             ready;
    logic             register_select;
    logic [NIB_W-1:0] nibble;
    logic             long_wait;
    logic             cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             last;

    modport source (output valid, output register_select, output nibble,
                    output long_wait, output cursor_row, output cursor_col,
                    output last, input ready);
    modport sink   (input valid, input register_select, input nibble,
                    input long_wait, input cursor_row, input cursor_col,
                    input last, output ready);
endinterface

// File: hw/rtl/lcdseq_front.sv
`timescale 1ns / 1ps
// Front end: accept requests, classify them into byte entries, track the cursor.
module lcdseq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lcdseq_req_if.sink          i_req,
    input  logic                i_q_full,
    output logic                o_push,
    output lcdseq_pkg::t_entry  o_entry
);
    import lcdseq_pkg::*;

    logic             r_row;
    logic [COL_W-1:0] r_col;
    logic             n_row;
    logic [COL_W-1:0] n_col;
    logic             accept;
    logic [6:0]       num;
    logic [14:0]      prod;
    logic [3:0]       tens;
    logic [6:0]       units;
    logic [VALUE_W-1:0] chr;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;

    // Divide by ten via reciprocal: exact for every input up to the clamp of 99
    assign num   = (i_req.value > {1'b0, NUMBER_MAX}) ? NUMBER_MAX : i_req.value[6:0];
    assign prod  = 15'(num) * 15'd205;
    assign tens  = prod[14:11];
    assign units = num - {tens, 3'b000} - {2'b00, tens, 1'b0};

    assign chr = (i_req.value >= GLYPH_BASE) ? GLYPH_ROM[i_req.value[5:0]] : i_req.value;

    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        o_push       = 1'b0;
        o_entry.kind = K_BYTE;
        o_entry.rs   = 1'b0;
        o_entry.lw   = 1'b0;
        o_entry.b0   = i_req.value;
        o_entry.b1   = '0;
        case (t_op'(i_req.operation))
            OP_CHAR: begin
                o_push     = accept;
                o_entry.rs = 1'b1;
                o_entry.b0 = chr;
            end
            OP_COMMAND: begin
                o_push = accept;
            end
            OP_GOTO: begin
                o_push     = accept;
                o_entry.b0 = {1'b1, i_req.row, i_req.column};
                if (accept) begin
                    n_row = i_req.row;
                    n_col = i_req.column;
                end
            end
            OP_NUMBER: begin
                o_push       = accept;
                o_entry.kind = K_PAIR;
                o_entry.rs   = 1'b1;
                o_entry.b0   = ASCII_ZERO | {4'b0000, tens};
                o_entry.b1   = ASCII_ZERO | {4'b0000, units[3:0]};
            end
            OP_CLEAR: begin
                o_push     = accept;
                o_entry.lw = 1'b1;
                o_entry.b0 = CMD_CLEAR;
                if (accept) begin
                    n_row = 1'b0;
                    n_col = '0;
                end
            end
            OP_INIT: begin
                o_push       = accept;
                o_entry.kind = K_INIT;
            end
            default: begin
                // undefined codes are swallowed without output
                o_push = 1'b0;
            end
        endcase
        o_entry.crow = n_row;
        o_entry.ccol = n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 1'b0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// File: hw/rtl/lcdseq_queue.sv
`timescale 1ns / 1ps
// Short entry queue between the front end and the nibble sequencer.
module lcdseq_queue #(
    parameter int DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcdseq_pkg::t_entry  i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output lcdseq_pkg::t_entry  o_head
);
    import lcdseq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// File: hw/rtl/lcdseq_back.sv
`timescale 1ns / 1ps
// Back end: play each queued entry out as nibbles into a registered output.
module lcdseq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lcdseq_pkg::t_entry  i_head,
    output logic                o_pop,
    lcdseq_nib_if.source        o_nib
);
    import lcdseq_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic             r_rs;
    logic [NIB_W-1:0] r_nib;
    logic             r_lw;
    logic             r_crow;
    logic [COL_W-1:0] r_ccol;
    logic             r_last;

    logic               fire;
    logic [VALUE_W-1:0] byte_sel;
    logic [NIB_W-1:0]   nib;
    logic               lw;
    logic               last;

    assign fire  = i_q_valid && (!r_valid || o_nib.ready);
    assign o_pop = fire && last;

    always_comb begin
        byte_sel = i_head.b0;
        nib      = '0;
        lw       = 1'b0;
        last     = 1'b0;
        case (i_head.kind)
            K_BYTE: begin
                nib  = r_idx[0] ? byte_sel[3:0] : byte_sel[7:4];
                lw   = r_idx[0] && i_head.lw;
                last = r_idx[0];
            end
            K_PAIR: begin
                byte_sel = r_idx[1] ? i_head.b1 : i_head.b0;
                nib      = r_idx[0] ? byte_sel[3:0] : byte_sel[7:4];
                last     = (r_idx == PAIR_LAST);
            end
            K_INIT: begin
                nib  = init_nibble(r_idx);
                lw   = !r_idx[0];
                last = (r_idx == INIT_LAST);
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_idx   <= last ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (o_nib.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rs   <= i_head.rs;
            r_nib  <= nib;
            r_lw   <= lw;
            r_crow <= i_head.crow;
            r_ccol <= i_head.ccol;
            r_last <= last;
        end
    end

    assign o_nib.valid           = r_valid;
    assign o_nib.register_select = r_rs;
    assign o_nib.nibble          = r_nib;
    assign o_nib.long_wait       = r_lw;
    assign o_nib.cursor_row      = r_crow;
    assign o_nib.cursor_col      = r_ccol;
    assign o_nib.last            = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= INIT_LAST)
        else $error("nibble index out of range");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == '0))
        else $error("nibble index not rewound with empty queue");

    a_last_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last) |=> (r_idx == '0) && r_last)
        else $error("final nibble did not rewind the index");

endmodule

// File: hw/rtl/char_lcd_nibble_command_sequencer.sv
`timescale 1ns / 1ps
// Top level of the character-LCD 4-bit nibble command sequencer.
//
//   port     | dir | handshake   | item
//   ---------+-----+-------------+---------------------------------------------
//   i_req    | in  | valid/ready | request: operation, value, row, column
//   o_nib    | out | valid/ready | nibble: rs, nibble, long_wait, cursor, last
//
// One nibble leaves per cycle from the output register while o_nib is ready;
// a character, command, goto or clear is two nibbles, a number four, an init eleven.
// The front end accepts a request while the queue has room, so the
// next request is accepted while the previous one is still being played out.
// Reset (synchronous, active low) empties the queue and the output register and
// puts the cursor at row 0, column 0.
// A stall on o_nib holds the output register; requests back up into the queue
// and i_req.ready drops only when it is full.
module char_lcd_nibble_command_sequencer #(
    parameter int QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF   // 2..8 entries
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcdseq_req_if.sink    i_req,
    lcdseq_nib_if.source  o_nib
);
    import lcdseq_pkg::*;

    // Front to queue: classified entry, pushed on accept of a defined operation
    logic   q_push;
    t_entry q_entry;
    logic   q_full;

    // Queue to back: head entry, popped after its final nibble
    logic   q_valid;
    t_entry q_head;
    logic   q_pop;

    lcdseq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_entry)
    );

    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    lcdseq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_nib     (o_nib)
    );

endmodule
